/* rtl/arpr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arpr_pkg
// shared constants, codes and types of the arp request responder
// ----------------------------------------------------------------------------
package arpr_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int MAX_BYTES   = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int ARP_LEN     = 28;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;
	localparam int CFG_W = 48;

	localparam logic [IP_W-1:0] OWN_IP_RESET = 32'hC0A8_0114;

	// register indexes of the configuration port
	localparam logic CFG_OWN_IP  = 1'b0;
	localparam logic CFG_OWN_MAC = 1'b1;

	typedef enum logic [2:0] {
		ST_REPLY    = 3'd0,
		ST_BAD_HDR  = 3'd1,
		ST_NOT_OURS = 3'd2,
		ST_NOT_REQ  = 3'd3,
		ST_BAD_LEN  = 3'd4
	} status_t;

	// verdict handed from the receive checker to the reply sequencer
	typedef struct packed {
		logic [CNT_W-1:0] len;
		status_t          status;
	} arpr_verdict_t;

	// fixed header bytes: htype 0x0001, ptype 0x0800, hlen 6, plen 4, oper 0x0001
	function automatic logic [7:0] hdr_byte(input logic [2:0] offset);
		logic [7:0] b;
		case (offset)
			3'd0:    b = 8'h00;
			3'd1:    b = 8'h01;
			3'd2:    b = 8'h08;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h06;
			3'd5:    b = 8'h04;
			3'd6:    b = 8'h00;
			3'd7:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* rtl/arpr_rx_check.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arpr_rx_check
// counts incoming bytes, checks the header on the fly and judges the packet
// ----------------------------------------------------------------------------
module arpr_rx_check (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire logic [7:0]                  data_byte,
	input  wire logic                        last_byte,
	input  wire logic [arpr_pkg::IP_W-1:0]   own_ip,
	output logic                             wr_en,
	output logic [arpr_pkg::ADDR_W-1:0]      wr_addr,
	output arpr_pkg::arpr_verdict_t          verdict
);
	import arpr_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             ovf_q, ovf_n;
	logic             hdr_ok_q, hdr_ok_n;
	logic             op_ok_q, op_ok_n;
	logic [IP_W-1:0]  tip_q, tip_n;

	// latched at the packet end
	logic [CNT_W-1:0] jlen_q;
	logic             jovf_q, jhdr_q, jop_q;
	logic [IP_W-1:0]  jtip_q;

	logic room;

	assign room    = (cnt_q < CNT_W'(MAX_BYTES));
	assign wr_en   = accept && room;
	assign wr_addr = cnt_q[ADDR_W-1:0];

	always_comb begin
		cnt_n    = cnt_q;
		ovf_n    = ovf_q;
		hdr_ok_n = hdr_ok_q;
		op_ok_n  = op_ok_q;
		tip_n    = tip_q;
		if (room) begin
			cnt_n = cnt_q + 1'b1;
			if (cnt_q < CNT_W'(6)) begin
				if (data_byte != hdr_byte(cnt_q[2:0])) hdr_ok_n = 1'b0;
			end else if (cnt_q < CNT_W'(8)) begin
				if (data_byte != hdr_byte(cnt_q[2:0])) op_ok_n = 1'b0;
			end else if (cnt_q >= CNT_W'(24) && cnt_q < CNT_W'(ARP_LEN)) begin
				tip_n = {tip_q[IP_W-9:0], data_byte};
			end
		end else begin
			ovf_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			hdr_ok_q <= 1'b1;
			op_ok_q  <= 1'b1;
			tip_q    <= '0;
			jlen_q   <= '0;
			jovf_q   <= 1'b0;
			jhdr_q   <= 1'b0;
			jop_q    <= 1'b0;
			jtip_q   <= '0;
		end else if (accept) begin
			if (last_byte) begin
				jlen_q   <= cnt_n;
				jovf_q   <= ovf_n;
				jhdr_q   <= hdr_ok_n;
				jop_q    <= op_ok_n;
				jtip_q   <= tip_n;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
				hdr_ok_q <= 1'b1;
				op_ok_q  <= 1'b1;
			end else begin
				cnt_q    <= cnt_n;
				ovf_q    <= ovf_n;
				hdr_ok_q <= hdr_ok_n;
				op_ok_q  <= op_ok_n;
				tip_q    <= tip_n;
			end
		end
	end

	// check order: length, header, target ip, opcode
	always_comb begin
		verdict.len = jlen_q;
		if (jovf_q || jlen_q < CNT_W'(ARP_LEN))
			verdict.status = ST_BAD_LEN;
		else if (!jhdr_q)
			verdict.status = ST_BAD_HDR;
		else if (jtip_q != own_ip)
			verdict.status = ST_NOT_OURS;
		else if (!jop_q)
			verdict.status = ST_NOT_REQ;
		else
			verdict.status = ST_REPLY;
	end

endmodule
`default_nettype wire

/* rtl/arp_request_responder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arp_request_responder
// answers arp requests for the own ipv4 address with an arp reply payload
// ----------------------------------------------------------------------------
// The block takes an ARP payload one byte per word on the slave stream, buffers it in a
// 64 x 8 single-port RAM and checks it once the word with tlast arrives. A request
// for own_ip is answered on the master stream with a reply as long as the input, one
// byte per word: opcode 2, the old sender moved to the target fields, own_mac and
// own_ip as the sender, padding copied. Any other packet gives one status word with
// tdata 0 and tlast set. Input runs at one byte per cycle while receiving; after the
// last byte the block passes through a judge state, then the reply streams out of the
// RAM through the registered read stage and the output register at one byte per cycle
// unless m_axis_tready stalls it; while it streams, no input is taken. The RAM port is
// shared between receive writes and reply reads. own_ip and own_mac are written through
// the cfg port while the block is idle: a rule for the user, the block does not enforce it.
// ----------------------------------------------------------------------------
module arp_request_responder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [arpr_pkg::CFG_W-1:0]   cfg_wdata,
	// arp payload in
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
	input  wire logic                         s_axis_tlast,  // last_byte
	// reply out
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // [7:0] reply_byte
	output logic                              m_axis_tlast,  // reply_last
	output logic [2:0]                        m_axis_tuser   // [2:0] status
);
	import arpr_pkg::*;

	typedef enum logic [1:0] {S_RX, S_JUDGE, S_TX} state_t;

	// configuration registers
	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= OWN_IP_RESET;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_IP:  own_ip_q  <= cfg_wdata[IP_W-1:0];
				CFG_OWN_MAC: own_mac_q <= cfg_wdata[MAC_W-1:0];
				default: ;
			endcase
		end
	end

	state_t state_q;

	logic              in_acc;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	arpr_verdict_t     verdict;

	assign s_axis_tready = (state_q == S_RX);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	arpr_rx_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_acc),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.own_ip    (own_ip_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.verdict   (verdict)
	);

	// reply read side
	logic [CNT_W-1:0]  rd_idx_q;
	logic [ADDR_W-1:0] rd_pos;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic              rd_last;

	logic              s1_valid;
	logic [ADDR_W-1:0] idx_s1;
	logic              last_s1;
	logic [7:0]        rdata_s1;
	logic              s1_move;
	logic              out_free;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	status_t           out_status_q;

	logic [7:0]        reply_byte;
	logic [2:0]        mac_k;
	logic [1:0]        ip_k;

	assign out_free = !out_valid_q || m_axis_tready;
	assign s1_move  = s1_valid && out_free;
	assign rd_en    = (state_q == S_TX) && (!s1_valid || s1_move);
	assign rd_last  = (rd_idx_q + 1'b1) == verdict.len;
	assign rd_pos   = rd_idx_q[ADDR_W-1:0];

	// target fields of the reply come from the old sender fields, ten bytes earlier
	always_comb begin
		if (rd_pos >= ADDR_W'(18) && rd_pos < ADDR_W'(ARP_LEN))
			rd_addr = rd_pos - ADDR_W'(10);
		else
			rd_addr = rd_pos;
	end

	// packet buffer
	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= s_axis_tdata;
		if (rd_en)
			rdata_s1 <= mem[rd_addr];
	end

	// sender fields and opcode are substituted on the way out
	assign mac_k = 3'(idx_s1 - ADDR_W'(8));
	assign ip_k  = 2'(idx_s1 - ADDR_W'(14));

	always_comb begin
		if (idx_s1 == ADDR_W'(7))
			reply_byte = 8'h02;
		else if (idx_s1 >= ADDR_W'(8) && idx_s1 < ADDR_W'(14))
			reply_byte = own_mac_q[8*(3'd5 - mac_k) +: 8];
		else if (idx_s1 >= ADDR_W'(14) && idx_s1 < ADDR_W'(18))
			reply_byte = own_ip_q[8*(2'd3 - ip_k) +: 8];
		else
			reply_byte = rdata_s1;
	end

	// sequencer with read stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_RX;
			rd_idx_q     <= '0;
			s1_valid     <= 1'b0;
			idx_s1       <= '0;
			last_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_last_q   <= 1'b0;
			out_status_q <= ST_REPLY;
		end else begin
			// output register
			if (s1_move) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= reply_byte;
				out_last_q   <= last_s1;
				out_status_q <= ST_REPLY;
			end else if (state_q == S_JUDGE && verdict.status != ST_REPLY
					&& !s1_valid && out_free) begin
				out_valid_q  <= 1'b1;
				out_byte_q   <= '0;
				out_last_q   <= 1'b1;
				out_status_q <= verdict.status;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			// read stage
			if (rd_en) begin
				s1_valid <= 1'b1;
				idx_s1   <= rd_pos;
				last_s1  <= rd_last;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end

			case (state_q)
				S_RX: begin
					if (in_acc && s_axis_tlast)
						state_q <= S_JUDGE;
				end
				S_JUDGE: begin
					if (verdict.status == ST_REPLY) begin
						rd_idx_q <= '0;
						state_q  <= S_TX;
					end else if (!s1_valid && out_free) begin
						state_q <= S_RX;
					end
				end
				S_TX: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_last)
							state_q <= S_RX;
					end
				end
				default: state_q <= S_RX;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

	// a status word always closes its packet
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_REPLY) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
		else $error("status word without tlast or with nonzero data");

	// the single ram port is never written and read in one cycle
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("ram write and read collide");

	// a held read stage word is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_move) |=> (s1_valid && $stable(idx_s1) && $stable(rdata_s1)))
		else $error("read stage lost a stalled word");

	// reads never run past the packet length
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_idx_q < verdict.len))
		else $error("reply read beyond packet length");

endmodule
`default_nettype wire
